FILE: src/wav_header_and_pcm_parser_unit_assert.svh
// ---------------------------------------------------------------------------
// WAV parser assertion macros
// Shared property forms for the checker of the WAV header and PCM parser.
// ---------------------------------------------------------------------------
`ifndef WAV_HEADER_AND_PCM_PARSER_UNIT_ASSERT_SVH
`define WAV_HEADER_AND_PCM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define WAVP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavp check failed");

// Next-cycle implication, checked only outside reset.
`define WAVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavp check failed");

// Next-cycle implication that also holds across reset.
`define WAVP_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wavp check failed");

`endif

FILE: src/wavp_pkg.sv
// ---------------------------------------------------------------------------
// wavp_pkg
// Constants, codes and helper functions of the WAV header and PCM parser.
// ---------------------------------------------------------------------------
package wavp_pkg;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 160;

  // Chunk tags as they arrive, first byte in the top bits.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Result kinds, carried on out_tuser.
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NOT_RIFF     = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE     = 3'd1;
  localparam logic [2:0] ERR_EXTRA_FMT    = 3'd2;
  localparam logic [2:0] ERR_NO_FMT       = 3'd3;
  localparam logic [2:0] ERR_BAD_DEPTH    = 3'd4;
  localparam logic [2:0] ERR_BAD_CHANNELS = 3'd5;

  localparam logic [15:0] DEPTH_16 = 16'd16;
  localparam logic [15:0] DEPTH_24 = 16'd24;

  // Running residue modulo 3 of a little-endian number built byte by byte.
  // Since 256 and 4 are both 1 modulo 3, the residue is the sum of the
  // 2-bit digits, folded down.
  function automatic logic [1:0] mod3_add(input logic [7:0] b, input logic [1:0] r);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]) + 4'(r);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    u = 3'(t[1:0]) + 3'(t[2]);
    mod3_add = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

endpackage

FILE: src/wav_header_and_pcm_parser_unit.sv
// ---------------------------------------------------------------------------
// wav_header_and_pcm_parser_unit
// Byte-serial RIFF/WAVE parser that reports the PCM format and emits samples.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of a WAV file per request on in_tdata,
// with in_tuser high on the first byte of a file. That byte restarts the
// parser from a clean state and is then parsed as the first byte.
// The output channel carries at most one result per input byte: a format
// report when the data chunk header completes, one signed Q1.23 sample per
// complete little-endian PCM sample (16-bit codes are shifted left by 8),
// or an error. out_tuser holds the kind, out_tdata the fields.
// The result of a byte sits in the output register on the cycle after the
// byte was taken. Throughput is one byte per cycle while the output is not
// stalled; the parse state is updated by a single register stage per byte.
// The output register parts the two sides: a new byte is taken whenever
// that register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the input only while a result is waiting.
// Reset empties the output register and puts the parser in front of the
// RIFF tag. After an error or after the last whole frame, bytes are taken
// and dropped until the next file start.
// ---------------------------------------------------------------------------
module wav_header_and_pcm_parser_unit
  import wavp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] file_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] error_code, [18:3] format_tag,
                                            // [34:19] channel_count, [66:35] rate_hz,
                                            // [82:67] frame_align, [98:83] sample_depth,
                                            // [130:99] data_bytes, [131] channel,
                                            // [155:132] sample_value, [159:156] zero
  output logic [1:0]            out_tuser   // [1:0] result_kind
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_HALT
  } phase_t;

  // Parse state.
  phase_t       phase_r, phase_nxt;
  logic [31:0]  cnt_r, cnt_nxt;         // byte offset in the phase or chunk
  logic [31:0]  tag_r, tag_nxt;
  logic [31:0]  len_r, len_nxt;
  logic [1:0]   res3_r, res3_nxt;       // chunk length modulo 3
  logic         fmt_seen_r, fmt_seen_nxt;
  logic [15:0]  fmt_code_r, fmt_code_nxt;
  logic [15:0]  chans_r, chans_nxt;
  logic [31:0]  rate_r, rate_nxt;
  logic [15:0]  align_r, align_nxt;
  logic [15:0]  depth_r, depth_nxt;
  logic [31:0]  remain_r, remain_nxt;   // bytes of whole frames still to come
  logic [23:0]  asm_r, asm_nxt;
  logic [1:0]   bis_r, bis_nxt;         // byte within the current sample
  logic         chan_r, chan_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // State as seen by the current byte, after a file start has cleared it.
  phase_t       cur_phase;
  logic [31:0]  cur_cnt, cur_tag, cur_len, cur_rate, cur_remain;
  logic [1:0]   cur_res3, cur_bis;
  logic         cur_fmt_seen, cur_chan;
  logic [15:0]  cur_fmt_code, cur_chans, cur_align, cur_depth;
  logic [23:0]  cur_asm;

  logic         accept;
  logic [7:0]   b;

  // Result of this byte.
  logic         emit;
  logic [1:0]   res_kind;
  logic [2:0]   res_err;
  logic         res_chan;
  logic [23:0]  res_sample;

  // Data header decode.
  logic [31:0]  hdr_tag, hdr_len, hdr_remain;
  logic [1:0]   hdr_res3;
  logic [2:0]   hdr_part;       // bytes of the trailing partial frame
  logic         depth_is16;
  logic [1:0]   lane;
  logic [31:0]  cnt_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    if (in_tuser) begin
      cur_phase    = PH_RIFF;
      cur_cnt      = '0;
      cur_tag      = '0;
      cur_len      = '0;
      cur_res3     = '0;
      cur_fmt_seen = 1'b0;
      cur_fmt_code = '0;
      cur_chans    = '0;
      cur_rate     = '0;
      cur_align    = '0;
      cur_depth    = '0;
      cur_remain   = '0;
      cur_asm      = '0;
      cur_bis      = '0;
      cur_chan     = 1'b0;
    end else begin
      cur_phase    = phase_r;
      cur_cnt      = cnt_r;
      cur_tag      = tag_r;
      cur_len      = len_r;
      cur_res3     = res3_r;
      cur_fmt_seen = fmt_seen_r;
      cur_fmt_code = fmt_code_r;
      cur_chans    = chans_r;
      cur_rate     = rate_r;
      cur_align    = align_r;
      cur_depth    = depth_r;
      cur_remain   = remain_r;
      cur_asm      = asm_r;
      cur_bis      = bis_r;
      cur_chan     = chan_r;
    end
  end

  assign cnt_inc    = cur_cnt + 32'd1;
  assign depth_is16 = (cur_depth == DEPTH_16);

  // Header bytes: the tag shifts in big-endian, the length lands byte by byte.
  always_comb begin
    hdr_tag  = (cur_cnt[2:0] == 3'd0) ? {24'd0, b} : {cur_tag[23:0], b};
    hdr_len  = cur_len;
    hdr_res3 = cur_res3;
    if (cur_cnt[2]) begin
      hdr_tag = cur_tag;
      hdr_len[{cur_cnt[1:0], 3'b000} +: 8] = b;
      hdr_res3 = mod3_add(b, (cur_cnt[1:0] == 2'd0) ? 2'd0 : cur_res3);
    end
  end

  // Whole-frame byte count of the data chunk: the length minus its remainder
  // modulo the frame size (2, 3, 4 or 6 bytes).
  always_comb begin
    if (depth_is16) begin
      hdr_part = (cur_chans == 16'd2) ? {1'b0, hdr_len[1:0]} : {2'b00, hdr_len[0]};
    end else if (cur_chans == 16'd2) begin
      hdr_part = {1'b0, hdr_res3} + ((hdr_res3[0] ^ hdr_len[0]) ? 3'd3 : 3'd0);
    end else begin
      hdr_part = {1'b0, hdr_res3};
    end
    hdr_remain = (cur_chans == 16'd0) ? 32'd0 : hdr_len - {29'd0, hdr_part};
  end

  assign lane = cur_bis + {1'b0, depth_is16};

  always_comb begin
    phase_nxt    = cur_phase;
    cnt_nxt      = cur_cnt;
    tag_nxt      = cur_tag;
    len_nxt      = cur_len;
    res3_nxt     = cur_res3;
    fmt_seen_nxt = cur_fmt_seen;
    fmt_code_nxt = cur_fmt_code;
    chans_nxt    = cur_chans;
    rate_nxt     = cur_rate;
    align_nxt    = cur_align;
    depth_nxt    = cur_depth;
    remain_nxt   = cur_remain;
    asm_nxt      = cur_asm;
    bis_nxt      = cur_bis;
    chan_nxt     = cur_chan;
    emit         = 1'b0;
    res_kind     = KIND_ERROR;
    res_err      = ERR_NOT_RIFF;
    res_chan     = 1'b0;
    res_sample   = '0;

    unique case (cur_phase)
      PH_RIFF, PH_WAVE: begin
        tag_nxt = {cur_tag[23:0], b};
        cnt_nxt = cnt_inc;
        if (cur_cnt[1:0] == 2'd3) begin
          cnt_nxt = '0;
          tag_nxt = '0;
          if (cur_phase == PH_RIFF) begin
            if ({cur_tag[23:0], b} != TAG_RIFF) begin
              emit      = 1'b1;
              res_err   = ERR_NOT_RIFF;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_RSIZE;
            end
          end else begin
            if ({cur_tag[23:0], b} != TAG_WAVE) begin
              emit      = 1'b1;
              res_err   = ERR_NOT_WAVE;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_HDR;
            end
          end
        end
      end
      PH_RSIZE: begin
        cnt_nxt = cnt_inc;
        if (cur_cnt[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          phase_nxt = PH_WAVE;
        end
      end
      PH_HDR: begin
        tag_nxt  = hdr_tag;
        len_nxt  = hdr_len;
        res3_nxt = hdr_res3;
        cnt_nxt  = cnt_inc;
        if (cur_cnt[2:0] == 3'd7) begin
          cnt_nxt = '0;
          if (hdr_tag == TAG_FMT) begin
            if (cur_fmt_seen) begin
              emit      = 1'b1;
              res_err   = ERR_EXTRA_FMT;
              phase_nxt = PH_HALT;
            end else begin
              fmt_seen_nxt = 1'b1;
              phase_nxt    = (hdr_len == 32'd0) ? PH_HDR : PH_FMT;
            end
          end else if (hdr_tag == TAG_DATA) begin
            emit      = 1'b1;
            phase_nxt = PH_HALT;
            if (!cur_fmt_seen) begin
              res_err = ERR_NO_FMT;
            end else if (cur_depth != DEPTH_16 && cur_depth != DEPTH_24) begin
              res_err = ERR_BAD_DEPTH;
            end else if (cur_chans > 16'd2) begin
              res_err = ERR_BAD_CHANNELS;
            end else begin
              res_kind   = KIND_FORMAT;
              remain_nxt = hdr_remain;
              bis_nxt    = '0;
              chan_nxt   = 1'b0;
              asm_nxt    = '0;
              phase_nxt  = (hdr_remain == 32'd0) ? PH_HALT : PH_DATA;
            end
          end else begin
            phase_nxt = (hdr_len == 32'd0) ? PH_HDR : PH_SKIP;
          end
        end
      end
      PH_FMT, PH_SKIP: begin
        if (cur_phase == PH_FMT) begin
          if (cur_cnt < 32'd2) begin
            fmt_code_nxt[{cur_cnt[0], 3'b000} +: 8] = b;
          end else if (cur_cnt < 32'd4) begin
            chans_nxt[{cur_cnt[0], 3'b000} +: 8] = b;
          end else if (cur_cnt < 32'd8) begin
            rate_nxt[{cur_cnt[1:0], 3'b000} +: 8] = b;
          end else if (cur_cnt >= 32'd12 && cur_cnt < 32'd14) begin
            align_nxt[{cur_cnt[0], 3'b000} +: 8] = b;
          end else if (cur_cnt >= 32'd14 && cur_cnt < 32'd16 && cur_len >= 32'd16) begin
            depth_nxt[{cur_cnt[0], 3'b000} +: 8] = b;
          end
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == cur_len) begin
          cnt_nxt   = '0;
          phase_nxt = cur_len[0] ? PH_PAD : PH_HDR;
        end
      end
      PH_PAD: begin
        cnt_nxt   = '0;
        phase_nxt = PH_HDR;
      end
      PH_DATA: begin
        asm_nxt = (cur_bis == 2'd0) ? 24'd0 : cur_asm;
        asm_nxt[{lane, 3'b000} +: 8] = b;
        remain_nxt = cur_remain - 32'd1;
        if (cur_remain == 32'd1) begin
          phase_nxt = PH_HALT;
        end
        if (cur_bis < (depth_is16 ? 2'd1 : 2'd2)) begin
          bis_nxt = cur_bis + 2'd1;
        end else begin
          bis_nxt    = '0;
          chan_nxt   = (cur_chans == 16'd2) ? !cur_chan : 1'b0;
          emit       = 1'b1;
          res_kind   = KIND_SAMPLE;
          res_chan   = cur_chan;
          res_sample = asm_nxt;
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  // Output register: load on a result, clear once the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_data_nxt  = '0;
      case (res_kind)
        KIND_FORMAT: begin
          out_data_nxt[18:3]   = cur_fmt_code;
          out_data_nxt[34:19]  = cur_chans;
          out_data_nxt[66:35]  = cur_rate;
          out_data_nxt[82:67]  = cur_align;
          out_data_nxt[98:83]  = cur_depth;
          out_data_nxt[130:99] = hdr_len;
        end
        KIND_SAMPLE: begin
          out_data_nxt[131]     = res_chan;
          out_data_nxt[155:132] = res_sample;
        end
        default: begin
          out_data_nxt[2:0] = res_err;
        end
      endcase
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      cnt_r       <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      res3_r      <= '0;
      fmt_seen_r  <= 1'b0;
      fmt_code_r  <= '0;
      chans_r     <= '0;
      rate_r      <= '0;
      align_r     <= '0;
      depth_r     <= '0;
      remain_r    <= '0;
      asm_r       <= '0;
      bis_r       <= '0;
      chan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        tag_r      <= tag_nxt;
        len_r      <= len_nxt;
        res3_r     <= res3_nxt;
        fmt_seen_r <= fmt_seen_nxt;
        fmt_code_r <= fmt_code_nxt;
        chans_r    <= chans_nxt;
        rate_r     <= rate_nxt;
        align_r    <= align_nxt;
        depth_r    <= depth_nxt;
        remain_r   <= remain_nxt;
        asm_r      <= asm_nxt;
        bis_r      <= bis_nxt;
        chan_r     <= chan_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/wavp_checker.sv
// ---------------------------------------------------------------------------
// wavp_checker
// Port-level checks of the WAV header and PCM parser, bound to its top level.
// ---------------------------------------------------------------------------
`include "wav_header_and_pcm_parser_unit_assert.svh"

module wavp_checker
  import wavp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // A stalled result holds.
  `WAVP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Reset leaves the output empty.
  `WAVP_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)

  // A sample carries nothing but its channel and value.
  `WAVP_ASSERT_SAME(a_sample_clean, out_tvalid && out_tuser == KIND_SAMPLE, out_tdata[130:0] == '0 && out_tdata[159:156] == '0)

  // An error carries only a defined code.
  `WAVP_ASSERT_SAME(a_error_clean, out_tvalid && out_tuser == KIND_ERROR, out_tdata[159:3] == '0 && out_tdata[2:0] <= ERR_BAD_CHANNELS)

  // A format report carries no error code and no sample.
  `WAVP_ASSERT_SAME(a_format_clean, out_tvalid && out_tuser == KIND_FORMAT, out_tdata[2:0] == '0 && out_tdata[159:131] == '0)

endmodule

bind wav_header_and_pcm_parser_unit wavp_checker u_wavp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
